// ===== rtl/fpspb_pkg.sv =====
`default_nettype none

package fpspb_pkg;

  localparam int unsigned SCREEN_WIDTH   = 1920;
  localparam int unsigned SCREEN_HEIGHT  = 1080;
  localparam int unsigned MAX_SPRITE_DIM = 1024;

  localparam int unsigned CNT_W   = 10;
  localparam int unsigned DIM_W   = 11;
  localparam int unsigned SCALE_W = 13;
  localparam int unsigned ORG_W   = 13;
  localparam int unsigned CFG_W   = 13;
  localparam int unsigned COORD_W = 11;
  localparam int unsigned FRAC_W  = 8;
  localparam int unsigned PROD_W  = DIM_W + SCALE_W;
  localparam int unsigned DST_W   = PROD_W - FRAC_W;
  localparam int unsigned POS_W   = DST_W + 1;
  localparam int unsigned PAL_DEPTH = 256;

  typedef enum logic [0:0] {
    OP_WRITE = 1'b0,
    OP_PIXEL = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    REG_DEST_X        = 3'd0,
    REG_DEST_Y        = 3'd1,
    REG_SCALE_FIXED   = 3'd2,
    REG_GLOBAL_ALPHA  = 3'd3,
    REG_SPRITE_WIDTH  = 3'd4,
    REG_SPRITE_HEIGHT = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    op_e        opcode;
    logic [7:0] index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] entry_alpha;
  } in_word_t;

  typedef struct packed {
    logic [COORD_W-1:0] x_start;
    logic [COORD_W-1:0] x_end;
    logic [COORD_W-1:0] y_start;
    logic [COORD_W-1:0] y_end;
    logic [31:0]        color;
  } out_word_t;

  typedef struct packed {
    logic             valid;
    logic [CNT_W-1:0] col;
    logic [CNT_W-1:0] row;
    logic [31:0]      entry;
  } pix_t;

  typedef struct packed {
    logic               vis;
    logic [COORD_W-1:0] lo;
    logic [COORD_W-1:0] hi;
  } span_t;

  function automatic logic [DIM_W-1:0] clamp_dim(logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > DIM_W'(MAX_SPRITE_DIM)) begin
      r = DIM_W'(MAX_SPRITE_DIM);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/fpspb_in_if.sv =====
`default_nettype none

interface fpspb_in_if import fpspb_pkg::*; ();
  logic     valid;
  logic     ready;
  in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/fpspb_out_if.sv =====
`default_nettype none

interface fpspb_out_if import fpspb_pkg::*; ();
  logic      valid;
  logic      ready;
  out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/fpspb_front.sv =====
`default_nettype none

module fpspb_front import fpspb_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             advance_i,
  input  wire logic             accept_i,
  input  wire in_word_t         word_i,
  input  wire logic [DIM_W-1:0] width_i,
  input  wire logic [DIM_W-1:0] height_i,
  output pix_t                  pix_o
);

  logic [31:0]      mem [PAL_DEPTH];
  logic [31:0]      entry_q;
  logic             valid_q;
  logic [CNT_W-1:0] col_q, col_d, row_q, row_d;
  logic [CNT_W-1:0] pcol_q, prow_q;
  logic [DIM_W-1:0] w, h, col_inc, row_inc;
  logic             is_pixel;

  assign is_pixel = accept_i && (word_i.opcode == OP_PIXEL);
  assign w        = clamp_dim(width_i);
  assign h        = clamp_dim(height_i);
  assign col_inc  = {1'b0, col_q} + DIM_W'(1);
  assign row_inc  = {1'b0, row_q} + DIM_W'(1);

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (col_inc >= w) begin
      col_d = '0;
      row_d = (row_inc >= h) ? '0 : row_inc[CNT_W-1:0];
    end else begin
      col_d = col_inc[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i && (word_i.opcode == OP_WRITE)) begin
      mem[word_i.index] <= {word_i.entry_alpha, word_i.red, word_i.green, word_i.blue};
    end
    if (is_pixel) begin
      entry_q <= mem[word_i.index];
    end
    if (advance_i) begin
      pcol_q  <= col_q;
      prow_q  <= row_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      col_q   <= '0;
      row_q   <= '0;
    end else begin
      if (advance_i) begin
        valid_q <= is_pixel;
      end
      if (is_pixel) begin
        col_q <= col_d;
        row_q <= row_d;
      end
    end
  end

  assign pix_o.valid = valid_q;
  assign pix_o.col   = pcol_q;
  assign pix_o.row   = prow_q;
  assign pix_o.entry = entry_q;

endmodule

`default_nettype wire

// ===== rtl/fpspb_span.sv =====
`default_nettype none

module fpspb_span import fpspb_pkg::*; (
  input  wire logic                     clk_i,
  input  wire logic                     en_i,
  input  wire logic signed [ORG_W-1:0]  origin_i,
  input  wire logic [CNT_W-1:0]         src_i,
  input  wire logic [SCALE_W-1:0]       scale_i,
  input  wire logic [COORD_W-1:0]       limit_i,
  output span_t                         span_o
);

  logic [PROD_W-1:0]       prod0_q, prod1_q;
  logic [DIM_W-1:0]        src_inc;
  logic [DST_W-1:0]        d0, d1, d1a;
  logic signed [POS_W-1:0] org, p0, p1, lim;

  assign src_inc = {1'b0, src_i} + DIM_W'(1);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod0_q <= PROD_W'({1'b0, src_i}) * PROD_W'(scale_i);
      prod1_q <= PROD_W'(src_inc) * PROD_W'(scale_i);
    end
  end

  assign d0  = prod0_q[PROD_W-1:FRAC_W];
  assign d1  = prod1_q[PROD_W-1:FRAC_W];
  assign d1a = (d1 <= d0) ? d0 + DST_W'(1) : d1;
  assign org = POS_W'(origin_i);
  assign p0  = org + signed'({1'b0, d0});
  assign p1  = org + signed'({1'b0, d1a});
  assign lim = signed'(POS_W'(limit_i));

  assign span_o.vis = !((p1 <= 0) || (p0 >= lim));
  assign span_o.lo  = (p0 < 0) ? '0 : p0[COORD_W-1:0];
  assign span_o.hi  = (p1 > lim) ? limit_i : p1[COORD_W-1:0];

endmodule

`default_nettype wire

// ===== rtl/fixed_point_scaled_palette_blit.sv =====
// Pixel path: palette read register, span and alpha registers, output register.
// Throughput: one word per cycle; palette reads and writes share a single-port array.
// The whole pipeline holds while the output register is full and not taken.
// Reset clears the valid bits, the column and row counters and the config registers.
// The palette has no reset; an entry must be written before a pixel refers to it.
`default_nettype none

module fixed_point_scaled_palette_blit import fpspb_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  fpspb_in_if.sink              in_i,
  fpspb_out_if.source           out_o,
  input  wire logic             cfg_we_i,
  input  wire logic [2:0]       cfg_idx_i,
  input  wire logic [CFG_W-1:0] cfg_data_i
);

  logic signed [ORG_W-1:0] dest_x_q, dest_y_q;
  logic [SCALE_W-1:0]      scale_q, scale_eff;
  logic [7:0]              galpha_q;
  logic [DIM_W-1:0]        width_q, height_q;

  logic      advance, accept;
  pix_t      pix;
  span_t     span_x, span_y;
  logic      valid2_q;
  logic [7:0] ea_q;
  logic [23:0] rgb_q;
  logic [15:0] amul;
  logic      out_valid_q;
  out_word_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dest_x_q <= '0;
      dest_y_q <= '0;
      scale_q  <= SCALE_W'(256);
      galpha_q <= 8'd255;
      width_q  <= DIM_W'(1);
      height_q <= DIM_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_DEST_X:        dest_x_q <= signed'(cfg_data_i[ORG_W-1:0]);
        REG_DEST_Y:        dest_y_q <= signed'(cfg_data_i[ORG_W-1:0]);
        REG_SCALE_FIXED:   scale_q  <= cfg_data_i[SCALE_W-1:0];
        REG_GLOBAL_ALPHA:  galpha_q <= cfg_data_i[7:0];
        REG_SPRITE_WIDTH:  width_q  <= cfg_data_i[DIM_W-1:0];
        REG_SPRITE_HEIGHT: height_q <= cfg_data_i[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  assign advance    = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && advance;
  assign in_i.ready = advance;
  assign scale_eff  = (scale_q == '0) ? SCALE_W'(1) : scale_q;

  fpspb_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .accept_i  (accept),
    .word_i    (in_i.data),
    .width_i   (width_q),
    .height_i  (height_q),
    .pix_o     (pix)
  );

  fpspb_span u_span_x (
    .clk_i    (clk_i),
    .en_i     (advance),
    .origin_i (dest_x_q),
    .src_i    (pix.col),
    .scale_i  (scale_eff),
    .limit_i  (COORD_W'(SCREEN_WIDTH)),
    .span_o   (span_x)
  );

  fpspb_span u_span_y (
    .clk_i    (clk_i),
    .en_i     (advance),
    .origin_i (dest_y_q),
    .src_i    (pix.row),
    .scale_i  (scale_eff),
    .limit_i  (COORD_W'(SCREEN_HEIGHT)),
    .span_o   (span_y)
  );

  assign amul = pix.entry[31:24] * galpha_q;

  always_ff @(posedge clk_i) begin
    if (advance) begin
      ea_q  <= amul[15:8];
      rgb_q <= pix.entry[23:0];
      out_q.x_start <= span_x.lo;
      out_q.x_end   <= span_x.hi;
      out_q.y_start <= span_y.lo;
      out_q.y_end   <= span_y.hi;
      out_q.color   <= {ea_q, rgb_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid2_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      valid2_q    <= pix.valid;
      out_valid_q <= valid2_q && (ea_q != 8'd0) && span_x.vis && span_y.vis;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

endmodule

`default_nettype wire

// ===== verif/tb_fixed_point_scaled_palette_blit.sv =====
`timescale 1ns / 100ps

module tb_fixed_point_scaled_palette_blit;
  import fpspb_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned HOLD_CYCLES = 120;
  localparam int unsigned PRINT_CAP = 100;

  class blit_scoreboard;
    logic [31:0]        palette [PAL_DEPTH];
    logic [CNT_W-1:0]   col_pos;
    logic [CNT_W-1:0]   row_pos;
    logic [ORG_W-1:0]   org_x;
    logic [ORG_W-1:0]   org_y;
    logic [SCALE_W-1:0] scale;
    logic [7:0]         alpha_gain;
    logic [DIM_W-1:0]   width;
    logic [DIM_W-1:0]   height;
    out_word_t          rect_q[$];
    int unsigned        mismatches;

    function new();
      col_pos = '0;
      row_pos = '0;
      org_x = '0;
      org_y = '0;
      scale = SCALE_W'(256);
      alpha_gain = 8'd255;
      width = DIM_W'(1);
      height = DIM_W'(1);
      mismatches = 0;
    endfunction

    function void set_reg(cfg_reg_e r, logic [CFG_W-1:0] v);
      case (r)
        REG_DEST_X: org_x = v[ORG_W-1:0];
        REG_DEST_Y: org_y = v[ORG_W-1:0];
        REG_SCALE_FIXED: scale = v[SCALE_W-1:0];
        REG_GLOBAL_ALPHA: alpha_gain = v[7:0];
        REG_SPRITE_WIDTH: width = v[DIM_W-1:0];
        REG_SPRITE_HEIGHT: height = v[DIM_W-1:0];
        default: ;
      endcase
    endfunction

    function longint limit_dim(logic [DIM_W-1:0] v);
      longint d;
      if (v == '0) begin
        d = 1;
      end else if (v > DIM_W'(MAX_SPRITE_DIM)) begin
        d = MAX_SPRITE_DIM;
      end else begin
        d = longint'(v);
      end
      return d;
    endfunction

    // Maps one source coordinate to a destination span clipped to [0, limit).
    function bit map_span(longint origin, longint src, longint step, longint limit,
                          output logic [COORD_W-1:0] lo, output logic [COORD_W-1:0] hi);
      longint d0, d1, p0, p1;
      d0 = (src * step) >>> 8;
      d1 = ((src + 1) * step) >>> 8;
      if (d1 <= d0) begin
        d1 = d0 + 1;
      end
      p0 = origin + d0;
      p1 = origin + d1;
      lo = '0;
      hi = '0;
      if (p1 <= 0 || p0 >= limit) begin
        return 1'b0;
      end
      if (p0 < 0) begin
        p0 = 0;
      end
      if (p1 > limit) begin
        p1 = limit;
      end
      lo = p0[COORD_W-1:0];
      hi = p1[COORD_W-1:0];
      return 1'b1;
    endfunction

    function void note_word(in_word_t w);
      logic [31:0] entry;
      logic [7:0]  eff_alpha;
      int unsigned prod;
      longint      c, r, wd, ht, step;
      out_word_t   res;
      if (w.opcode == OP_WRITE) begin
        palette[w.index] = {w.entry_alpha, w.red, w.green, w.blue};
        return;
      end
      c = longint'(col_pos);
      r = longint'(row_pos);
      wd = limit_dim(width);
      ht = limit_dim(height);
      if (c + 1 >= wd) begin
        col_pos = '0;
        row_pos = (r + 1 >= ht) ? '0 : CNT_W'(r + 1);
      end else begin
        col_pos = CNT_W'(c + 1);
      end
      step = (scale == '0) ? 1 : longint'(scale);
      entry = palette[w.index];
      prod = int'(entry[31:24]) * int'(alpha_gain);
      eff_alpha = prod[15:8];
      if (entry[31:24] == 8'd0 || eff_alpha == 8'd0) begin
        return;
      end
      if (!map_span(longint'($signed(org_y)), r, step, SCREEN_HEIGHT, res.y_start, res.y_end)) begin
        return;
      end
      if (!map_span(longint'($signed(org_x)), c, step, SCREEN_WIDTH, res.x_start, res.x_end)) begin
        return;
      end
      res.color = {eff_alpha, entry[23:0]};
      rect_q.push_back(res);
    endfunction

    task report_mismatch(string msg);
      if (mismatches < PRINT_CAP) begin
        $display("[%0t] mismatch: %s", $realtime, msg);
      end
      mismatches++;
    endtask

    task check_result(out_word_t got);
      out_word_t want;
      if (rect_q.size() == 0) begin
        report_mismatch($sformatf("unexpected word %p", got));
        return;
      end
      want = rect_q.pop_front();
      if (got.x_start !== want.x_start) begin
        report_mismatch($sformatf("x_start %0d, expected %0d", got.x_start, want.x_start));
      end
      if (got.x_end !== want.x_end) begin
        report_mismatch($sformatf("x_end %0d, expected %0d", got.x_end, want.x_end));
      end
      if (got.y_start !== want.y_start) begin
        report_mismatch($sformatf("y_start %0d, expected %0d", got.y_start, want.y_start));
      end
      if (got.y_end !== want.y_end) begin
        report_mismatch($sformatf("y_end %0d, expected %0d", got.y_end, want.y_end));
      end
      if (got.color !== want.color) begin
        report_mismatch($sformatf("color %h, expected %h", got.color, want.color));
      end
    endtask

    task flush_check();
      if (rect_q.size() != 0) begin
        report_mismatch($sformatf("%0d expected words never arrived", rect_q.size()));
      end
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we;
  logic [2:0] cfg_idx;
  logic [CFG_W-1:0] cfg_data;

  fpspb_in_if in_if();
  fpspb_out_if out_if();

  fixed_point_scaled_palette_blit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_if),
    .out_o      (out_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  blit_scoreboard sb;
  int unsigned cycles = 0;
  bit steady;
  bit squeeze;
  bit idx_written [PAL_DEPTH];
  logic [7:0] used_idx[$];

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      sb.check_result(out_if.data);
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (steady) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end
    if (r < 85) begin
      return $urandom_range(1, 3);
    end
    if (r < 97) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 45);
  endfunction

  initial begin
    int unsigned ready_gap;
    ready_gap = 0;
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (squeeze) begin
        out_if.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        squeeze = 1'b0;
      end
      if (ready_gap > 0) begin
        out_if.ready = 1'b0;
        ready_gap--;
      end else begin
        out_if.ready = 1'b1;
        ready_gap = pick_gap();
      end
    end
  end

  task send_word(in_word_t w);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_if.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.valid = 1'b1;
    in_if.data = w;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    sb.note_word(w);
    @(negedge clk_i);
  endtask

  task pal_write(logic [7:0] idx, logic [31:0] argb);
    in_word_t w;
    w.opcode = OP_WRITE;
    w.index = idx;
    w.entry_alpha = argb[31:24];
    w.red = argb[23:16];
    w.green = argb[15:8];
    w.blue = argb[7:0];
    if (!idx_written[idx]) begin
      idx_written[idx] = 1'b1;
      used_idx.push_back(idx);
    end
    send_word(w);
  endtask

  task pixel(logic [7:0] idx);
    in_word_t w;
    w.opcode = OP_PIXEL;
    w.index = idx;
    w.entry_alpha = 8'($urandom);
    w.red = 8'($urandom);
    w.green = 8'($urandom);
    w.blue = 8'($urandom);
    send_word(w);
  endtask

  task write_reg(cfg_reg_e r, logic [CFG_W-1:0] v);
    cfg_we = 1'b1;
    cfg_idx = r;
    cfg_data = v;
    @(negedge clk_i);
    sb.set_reg(r, v);
  endtask

  task configure(logic [CFG_W-1:0] x, logic [CFG_W-1:0] y, logic [CFG_W-1:0] s,
                 logic [CFG_W-1:0] ga, logic [CFG_W-1:0] w, logic [CFG_W-1:0] h);
    write_reg(REG_DEST_X, x);
    write_reg(REG_DEST_Y, y);
    write_reg(REG_SCALE_FIXED, s);
    write_reg(REG_GLOBAL_ALPHA, ga);
    write_reg(REG_SPRITE_WIDTH, w);
    write_reg(REG_SPRITE_HEIGHT, h);
    cfg_we = 1'b0;
  endtask

  task drain();
    in_if.valid = 1'b0;
    while (sb.rect_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task random_config();
    logic [CFG_W-1:0] x, y, s, ga, w, h;
    if ($urandom_range(0, 9) < 8) begin
      x = CFG_W'($urandom_range(0, 1980)) - CFG_W'(40);
      y = CFG_W'($urandom_range(0, 1160)) - CFG_W'(40);
    end else begin
      x = CFG_W'($urandom);
      y = CFG_W'($urandom);
    end
    case ($urandom_range(0, 9))
      0: s = '0;
      1: s = CFG_W'($urandom_range(1025, 8191));
      default: s = CFG_W'($urandom_range(1, 1024));
    endcase
    ga = ($urandom_range(0, 9) == 0) ? '0 : CFG_W'($urandom_range(1, 255));
    if ($urandom_range(0, 4) == 0) begin
      ga[CFG_W-1:8] = 5'($urandom);
    end
    w = ($urandom_range(0, 3) != 0) ? CFG_W'($urandom_range(1, 16)) : CFG_W'($urandom_range(0, 2047));
    h = ($urandom_range(0, 3) != 0) ? CFG_W'($urandom_range(1, 16)) : CFG_W'($urandom_range(0, 2047));
    configure(x, y, s, ga, w, h);
  endtask

  task run_phase(int unsigned n_items);
    logic [31:0] argb;
    repeat (n_items) begin
      if ($urandom_range(0, 99) < 15) begin
        argb = $urandom;
        if ($urandom_range(0, 99) < 15) begin
          argb[31:24] = 8'd0;
        end
        pal_write(8'($urandom), argb);
      end else begin
        pixel(used_idx[$urandom_range(0, used_idx.size() - 1)]);
      end
    end
  endtask

  initial begin
    sb = new();
    rst_ni = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_data = '0;
    in_if.valid = 1'b0;
    in_if.data = '0;
    steady = 1'b0;
    squeeze = 1'b0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset settings: one-pixel sprite at the origin, unit scale, full alpha.
    pal_write(8'd0, 32'hFF000000);
    pal_write(8'd255, 32'h00FFFFFF);
    pal_write(8'd1, 32'h01FFFFFF);
    pal_write(8'd2, 32'h80123456);
    pixel(8'd0);
    pixel(8'd255);
    pixel(8'd1);
    pixel(8'd2);
    pal_write(8'd0, 32'hFFFFFFFF);
    pixel(8'd0);

    // Zero scale, zero width, oversized height, origin far off screen.
    drain();
    configure(13'h1000, 13'h0FFF, 13'd0, 13'd1, 13'd0, 13'h07FF);
    pixel(8'd0);
    pixel(8'd2);
    pixel(8'd0);

    // Largest scale near the bottom right corner.
    drain();
    configure(13'd1918, 13'd1078, 13'h1FFF, 13'd255, 13'd2, 13'd2);
    repeat (4) pixel(8'd0);

    // Partly off the top left edge at sixteen times magnification.
    drain();
    configure(13'h1FFB, 13'h1FFF, 13'd4096, 13'd128, 13'd3, 13'd1024);
    pixel(8'd2);
    pixel(8'd0);
    pixel(8'd255);
    pixel(8'd0);

    for (int p = 0; p < 8; p++) begin
      drain();
      random_config();
      steady = (p == 2 || p == 5);
      // The receiver holds off while words keep coming, so the input backs up.
      squeeze = (p == 5);
      run_phase(50);
    end
    steady = 1'b0;

    drain();
    sb.flush_check();
    if (sb.mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
